/* design/segment_intersection_defines.svh */
// Assertion macros for the segment intersection block.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define SI_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
`define SI_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SI_ASSERT_IMP(lbl, a, c)
`define SI_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* design/si_pkg.sv */
// Widths and types shared by the segment intersection block.
package si_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int OutBits   = 24;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int NumBits   = CrossBits + DiffBits + 1;
  localparam int ShBits    = NumBits + FracBits;
  localparam int DivBits   = ShBits + 2;
  localparam int DenBits   = CrossBits;
  localparam int DivFirst  = 9;
  localparam int NumStages = DivFirst + OutBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef logic signed [NumBits-1:0]   num_t;
  typedef logic [ShBits-1:0]           mag_t;
  typedef logic [DivBits-1:0]          div_t;
  typedef logic [DenBits-1:0]          den_t;
  typedef logic [OutBits-1:0]          quo_t;
  typedef logic signed [OutBits-1:0]   fix_t;
endpackage

/* design/si_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module si_div (
  input  logic                     clk_i,
  input  logic [si_pkg::OutBits-1:0] en_i,
  input  si_pkg::div_t             n_i,
  input  si_pkg::den_t             d_i,
  output si_pkg::quo_t             q_o
);
  import si_pkg::*;

  div_t r_q [OutBits-1];
  den_t d_q [OutBits-1];
  quo_t q_q [OutBits];

  for (genvar k = 0; k < OutBits; k++) begin : g_stage
    localparam int Bit = OutBits - 1 - k;
    div_t r_in, r_sh, r_nx;
    den_t d_in;
    quo_t q_in, q_nx;
    logic ge;

    if (k == 0) begin : g_first
      assign r_in = n_i;
      assign d_in = d_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
    end

    always_comb begin
      r_sh = DivBits'(d_in) << Bit;
      ge   = r_in >= r_sh;
      r_nx = ge ? r_in - r_sh : r_in;
      q_nx = q_in;
      q_nx[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        q_q[k] <= q_nx;
      end
    end

    if (k < OutBits - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          r_q[k] <= r_nx;
          d_q[k] <= d_in;
        end
      end
    end
  end

  assign q_o = q_q[OutBits-1];
endmodule

/* design/segment_intersection.sv */
// Top level of the segment intersection block.
// Takes one segment pair per cycle unless the input is stalled and returns one result per pair,
// in order, on the ports. Nine stages form the differences, cross products, crossing
// numerators and dividends, then a 24-stage restoring divider (one quotient bit per stage,
// x and y in parallel) and an output register. Each stage holds a valid bit; a stall at the
// output fills bubbles first, so input is stalled only once every stage is full.
`include "segment_intersection_defines.svh"
module segment_intersection (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  si_pkg::coord_t a_start_x_i,
  input  si_pkg::coord_t a_start_y_i,
  input  si_pkg::coord_t a_end_x_i,
  input  si_pkg::coord_t a_end_y_i,
  input  si_pkg::coord_t b_start_x_i,
  input  si_pkg::coord_t b_start_y_i,
  input  si_pkg::coord_t b_end_x_i,
  input  si_pkg::coord_t b_end_y_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           meets_o,
  output logic           is_parallel_o,
  output si_pkg::fix_t   cross_x_o,
  output si_pkg::fix_t   cross_y_o
);
  import si_pkg::*;

  typedef struct packed {
    coord_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } s0_t;
  typedef struct packed {
    diff_t dax, day, dbx, dby, wx, wy, bex, bey, aex, aey;
    coord_t ax1, ay1;
    logic [3:0] box;
  } s1_t;
  typedef struct packed {
    prod_t pa, pb, pt1, pt2, pu1, pu2, pe1, pe2, pf1, pf2;
    diff_t dax, day;
    coord_t ax1, ay1;
    logic [3:0] box;
  } s2_t;
  typedef struct packed {
    cross_t det, tn, un, cbe, cae;
    diff_t dax, day;
    coord_t ax1, ay1;
    logic [3:0] box;
  } s3_t;
  typedef struct packed {
    logic par, pmeet;
    cross_t detp, tnp, unp;
    diff_t dax, day;
    coord_t ax1, ay1;
  } s4_t;
  typedef struct packed {
    logic par, meets;
    cross_t detp;
    num_t mx1, mx2, my1, my2;
  } s5_t;
  typedef struct packed {
    logic par, meets, negx, negy;
    cross_t detp;
    mag_t magx, magy;
  } s6_t;
  typedef struct packed {
    logic par, meets, negx, negy;
    div_t nnx, nny;
    den_t den;
  } s7_t;
  typedef struct packed {
    logic par, meets, negx, negy, ovfx, ovfy;
    div_t nnx, nny;
    den_t den;
  } s8_t;
  typedef struct packed {
    logic par, meets, negx, negy, ovfx, ovfy;
  } side_t;

  function automatic logic in_rng(coord_t p, coord_t s, coord_t e);
    return ((p >= s) && (p <= e)) || ((p >= e) && (p <= s));
  endfunction

  function automatic fix_t sat(quo_t q, logic neg, logic ovf, logic par);
    fix_t r;
    if (par) begin
      r = '0;
    end else if (neg) begin
      if (ovf || (q[OutBits-1] && (|q[OutBits-2:0]))) begin
        r = {1'b1, {(OutBits-1){1'b0}}};
      end else begin
        r = $signed(quo_t'(~q + quo_t'(1)));
      end
    end else begin
      if (ovf || q[OutBits-1]) begin
        r = {1'b0, {(OutBits-1){1'b1}}};
      end else begin
        r = $signed(q);
      end
    end
    return r;
  endfunction

  logic [NumStages-1:0] v_q, en;

  assign en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  s0_t s0_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  s8_t s8_d, s8_q;
  side_t side_q [OutBits];
  quo_t qx, qy;
  num_t nx, ny;

  always_comb begin
    s1_d.dax = DiffBits'(s0_q.ax2) - DiffBits'(s0_q.ax1);
    s1_d.day = DiffBits'(s0_q.ay2) - DiffBits'(s0_q.ay1);
    s1_d.dbx = DiffBits'(s0_q.bx2) - DiffBits'(s0_q.bx1);
    s1_d.dby = DiffBits'(s0_q.by2) - DiffBits'(s0_q.by1);
    s1_d.wx  = DiffBits'(s0_q.bx1) - DiffBits'(s0_q.ax1);
    s1_d.wy  = DiffBits'(s0_q.by1) - DiffBits'(s0_q.ay1);
    s1_d.bex = DiffBits'(s0_q.bx2) - DiffBits'(s0_q.ax1);
    s1_d.bey = DiffBits'(s0_q.by2) - DiffBits'(s0_q.ay1);
    s1_d.aex = DiffBits'(s0_q.ax2) - DiffBits'(s0_q.bx1);
    s1_d.aey = DiffBits'(s0_q.ay2) - DiffBits'(s0_q.by1);
    s1_d.ax1 = s0_q.ax1;
    s1_d.ay1 = s0_q.ay1;
    s1_d.box[0] = in_rng(s0_q.bx1, s0_q.ax1, s0_q.ax2) && in_rng(s0_q.by1, s0_q.ay1, s0_q.ay2);
    s1_d.box[1] = in_rng(s0_q.bx2, s0_q.ax1, s0_q.ax2) && in_rng(s0_q.by2, s0_q.ay1, s0_q.ay2);
    s1_d.box[2] = in_rng(s0_q.ax1, s0_q.bx1, s0_q.bx2) && in_rng(s0_q.ay1, s0_q.by1, s0_q.by2);
    s1_d.box[3] = in_rng(s0_q.ax2, s0_q.bx1, s0_q.bx2) && in_rng(s0_q.ay2, s0_q.by1, s0_q.by2);
  end

  always_comb begin
    s2_d.pa  = ProdBits'(s1_q.dax) * ProdBits'(s1_q.dby);
    s2_d.pb  = ProdBits'(s1_q.day) * ProdBits'(s1_q.dbx);
    s2_d.pt1 = ProdBits'(s1_q.wx)  * ProdBits'(s1_q.dby);
    s2_d.pt2 = ProdBits'(s1_q.wy)  * ProdBits'(s1_q.dbx);
    s2_d.pu1 = ProdBits'(s1_q.wx)  * ProdBits'(s1_q.day);
    s2_d.pu2 = ProdBits'(s1_q.wy)  * ProdBits'(s1_q.dax);
    s2_d.pe1 = ProdBits'(s1_q.dax) * ProdBits'(s1_q.bey);
    s2_d.pe2 = ProdBits'(s1_q.day) * ProdBits'(s1_q.bex);
    s2_d.pf1 = ProdBits'(s1_q.dbx) * ProdBits'(s1_q.aey);
    s2_d.pf2 = ProdBits'(s1_q.dby) * ProdBits'(s1_q.aex);
    s2_d.dax = s1_q.dax;
    s2_d.day = s1_q.day;
    s2_d.ax1 = s1_q.ax1;
    s2_d.ay1 = s1_q.ay1;
    s2_d.box = s1_q.box;
  end

  always_comb begin
    s3_d.det = CrossBits'(s2_q.pa)  - CrossBits'(s2_q.pb);
    s3_d.tn  = CrossBits'(s2_q.pt1) - CrossBits'(s2_q.pt2);
    s3_d.un  = CrossBits'(s2_q.pu1) - CrossBits'(s2_q.pu2);
    s3_d.cbe = CrossBits'(s2_q.pe1) - CrossBits'(s2_q.pe2);
    s3_d.cae = CrossBits'(s2_q.pf1) - CrossBits'(s2_q.pf2);
    s3_d.dax = s2_q.dax;
    s3_d.day = s2_q.day;
    s3_d.ax1 = s2_q.ax1;
    s3_d.ay1 = s2_q.ay1;
    s3_d.box = s2_q.box;
  end

  // endpoint on other segment: its cross product is zero and it lies in the box
  always_comb begin
    s4_d.par   = s3_q.det == '0;
    s4_d.pmeet = ((s3_q.un == '0) && s3_q.box[0]) || ((s3_q.cbe == '0) && s3_q.box[1]) ||
                 ((s3_q.tn == '0) && s3_q.box[2]) || ((s3_q.cae == '0) && s3_q.box[3]);
    s4_d.detp  = s3_q.det[CrossBits-1] ? -s3_q.det : s3_q.det;
    s4_d.tnp   = s3_q.det[CrossBits-1] ? -s3_q.tn  : s3_q.tn;
    s4_d.unp   = s3_q.det[CrossBits-1] ? -s3_q.un  : s3_q.un;
    s4_d.dax   = s3_q.dax;
    s4_d.day   = s3_q.day;
    s4_d.ax1   = s3_q.ax1;
    s4_d.ay1   = s3_q.ay1;
  end

  always_comb begin
    s5_d.par   = s4_q.par;
    s5_d.meets = s4_q.par ? s4_q.pmeet :
                 ((s4_q.tnp >= 0) && (s4_q.tnp <= s4_q.detp) &&
                  (s4_q.unp >= 0) && (s4_q.unp <= s4_q.detp));
    s5_d.detp  = s4_q.detp;
    s5_d.mx1   = NumBits'(s4_q.ax1) * NumBits'(s4_q.detp);
    s5_d.mx2   = NumBits'(s4_q.dax) * NumBits'(s4_q.tnp);
    s5_d.my1   = NumBits'(s4_q.ay1) * NumBits'(s4_q.detp);
    s5_d.my2   = NumBits'(s4_q.day) * NumBits'(s4_q.tnp);
  end

  always_comb begin
    nx = s5_q.mx1 + s5_q.mx2;
    ny = s5_q.my1 + s5_q.my2;
    s6_d.par   = s5_q.par;
    s6_d.meets = s5_q.meets;
    s6_d.detp  = s5_q.detp;
    s6_d.negx  = nx[NumBits-1];
    s6_d.negy  = ny[NumBits-1];
    s6_d.magx  = ShBits'($unsigned(nx[NumBits-1] ? -nx : nx)) << FracBits;
    s6_d.magy  = ShBits'($unsigned(ny[NumBits-1] ? -ny : ny)) << FracBits;
  end

  // round half away from zero: (2|n| + d) / (2d)
  always_comb begin
    s7_d.par   = s6_q.par;
    s7_d.meets = s6_q.meets;
    s7_d.negx  = s6_q.negx;
    s7_d.negy  = s6_q.negy;
    s7_d.nnx   = (DivBits'(s6_q.magx) << 1) + DivBits'($unsigned(s6_q.detp));
    s7_d.nny   = (DivBits'(s6_q.magy) << 1) + DivBits'($unsigned(s6_q.detp));
    s7_d.den   = den_t'($unsigned(s6_q.detp)) << 1;
  end

  always_comb begin
    s8_d.par   = s7_q.par;
    s8_d.meets = s7_q.meets;
    s8_d.negx  = s7_q.negx;
    s8_d.negy  = s7_q.negy;
    s8_d.ovfx  = s7_q.nnx >= (DivBits'(s7_q.den) << OutBits);
    s8_d.ovfy  = s7_q.nny >= (DivBits'(s7_q.den) << OutBits);
    s8_d.nnx   = s7_q.nnx;
    s8_d.nny   = s7_q.nny;
    s8_d.den   = s7_q.den;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= '{ax1: a_start_x_i, ay1: a_start_y_i, ax2: a_end_x_i, ay2: a_end_y_i,
                bx1: b_start_x_i, by1: b_start_y_i, bx2: b_end_x_i, by2: b_end_y_i};
    end
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) s5_q <= s5_d;
    if (en[6]) s6_q <= s6_d;
    if (en[7]) s7_q <= s7_d;
    if (en[8]) s8_q <= s8_d;
    if (en[DivFirst]) begin
      side_q[0] <= '{par: s8_q.par, meets: s8_q.meets, negx: s8_q.negx, negy: s8_q.negy,
                     ovfx: s8_q.ovfx, ovfy: s8_q.ovfy};
    end
    for (int k = 1; k < OutBits; k++) begin
      if (en[DivFirst+k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    if (en[NumStages-1]) begin
      meets_o       <= side_q[OutBits-1].meets;
      is_parallel_o <= side_q[OutBits-1].par;
      cross_x_o     <= sat(qx, side_q[OutBits-1].negx, side_q[OutBits-1].ovfx,
                           side_q[OutBits-1].par);
      cross_y_o     <= sat(qy, side_q[OutBits-1].negy, side_q[OutBits-1].ovfy,
                           side_q[OutBits-1].par);
    end
  end

  si_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: OutBits]),
    .n_i   (s8_q.nnx),
    .d_i   (s8_q.den),
    .q_o   (qx)
  );

  si_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: OutBits]),
    .n_i   (s8_q.nny),
    .d_i   (s8_q.den),
    .q_o   (qy)
  );

  `SI_ASSERT_IMP(a_par_zero, out_valid_o && is_parallel_o, cross_x_o == '0 && cross_y_o == '0)
  `SI_ASSERT_IMP(a_full_stall, (&v_q) && out_stall_i, in_stall_o)
  `SI_ASSERT_NXT(a_accept_lands, in_valid_i && !in_stall_o, v_q[0])
endmodule
